### sv/spq_pkg.sv
// shared types and constants of the stable priority queue
// used by the cell, the top level, the checker and the testbench; no dependencies
package spq_pkg;

   // number of cells in the chain
   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // request mode codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // one stored entry
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [15:0] rank;
   } entry_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic      ins;
      logic      pop;
      entry_type item;
   } op_type;

   // count to the 6-bit response field (wraps above 63)
   function automatic logic [5:0] count_field(input logic [CNT_W-1:0] c);
      logic [CNT_W+5:0] wide;
      wide = {6'd0, c};
      return wide[5:0];
   endfunction

endpackage

### sv/spq_cell.sv
// one cell of the sorted chain: holds one entry and moves it left or right
// depends on spq_pkg
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  op_type    op,
   input  logic      occupied,
   input  logic      left_keep,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output logic      keep,
   output entry_type entry,
   output entry_type entry_next
);

   entry_type entry_ff;
   entry_type entry_in;

   // entry stays put when it outranks or ties the new word
   assign keep = occupied && (entry_ff.rank >= op.item.rank);

   // next content of the cell
   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = op.item;
         end else begin
            entry_in = left_entry;
         end
      end else if (op.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

### sv/stable_priority_queue.sv
// top level of the stable priority queue: a chain of spq_cell instances
// plus the entry counter and the response register; depends on spq_pkg
//
// Usage:
//   req_ channel carries one word: req_mode (insert or pop), req_item_value
//   and req_item_priority. A word is taken at a clock edge with req_valid
//   high and req_stall low. rsp_ channel returns exactly one word per request
//   with status, popped value, head value, head flag and entry count.
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one request per cycle while req_stall is low; every cell
//   compares its own priority against the new word in parallel, so insert and
//   pop both update the chain at the clock edge that takes the word.
//   Higher priority leaves first; equal priorities leave in arrival order.
//   A pop on an empty queue or an insert into a full one returns an error
//   status and leaves the store untouched.
//   Reset (synchronous, active high) empties the queue and drops any pending
//   response; the cells keep their content, which is never read unwritten.
//   While rsp_stall holds a pending response, req_stall is raised and the
//   response word stays unchanged; a response taken in the same cycle frees
//   room for the next request.
module stable_priority_queue
   import spq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic signed [31:0] req_item_value,
   input  logic signed [15:0] req_item_priority,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_popped_value,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_head_value,
   output logic               rsp_head_present,
   output logic        [5:0]  rsp_entry_count
);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   popped_ff, popped_in;
   logic [1:0]           status_ff, status_in;
   logic signed [31:0]   head_ff, head_in;
   logic                 present_ff, present_in;
   logic [5:0]           ecount_ff, ecount_in;

   logic                 accept;
   logic                 full;
   logic                 empty;
   op_type               op;
   logic [CAPACITY-1:0]  keep;
   entry_type            cur  [CAPACITY];
   entry_type            nxt  [CAPACITY];

   // handshake: take a word when the response slot is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   // operation sent down the chain
   always_comb begin
      op.ins        = accept && (req_mode == MODE_INSERT) && !full;
      op.pop        = accept && (req_mode == MODE_POP) && !empty;
      op.item.value = req_item_value;
      op.item.rank  = req_item_priority;
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occ;
      logic      lkeep;
      entry_type lent;
      entry_type rent;

      assign occ = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign lkeep = 1'b1;
         assign lent  = op.item;
      end else begin : g_mid
         assign lkeep = keep[i-1];
         assign lent  = cur[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rent = cur[i];
      end else begin : g_inner
         assign rent = cur[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .op          (op),
         .occupied    (occ),
         .left_keep   (lkeep),
         .left_entry  (lent),
         .right_entry (rent),
         .keep        (keep[i]),
         .entry       (cur[i]),
         .entry_next  (nxt[i])
      );
   end

   // count and response word
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      popped_in    = popped_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      present_in   = present_ff;
      ecount_in    = ecount_ff;
      if (op.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         popped_in    = op.pop ? cur[0].value : 32'sd0;
         if (req_mode == MODE_POP) begin
            status_in = empty ? ST_EMPTY : ST_OK;
         end else begin
            status_in = full ? ST_FULL : ST_OK;
         end
         present_in = (count_in != '0);
         head_in    = present_in ? nxt[0].value : 32'sd0;
         ecount_in  = count_field(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      popped_ff  <= popped_in;
      status_ff  <= status_in;
      head_ff    <= head_in;
      present_ff <= present_in;
      ecount_ff  <= ecount_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_head_value   = head_ff;
   assign rsp_head_present = present_ff;
   assign rsp_entry_count  = ecount_ff;

endmodule

### sv/spq_checker.sv
// port-level checks of the stable priority queue and their bind
// depends on spq_pkg and stable_priority_queue
module spq_checker
   import spq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_popped_value,
   input logic        [1:0]  rsp_status,
   input logic signed [31:0] rsp_head_value,
   input logic               rsp_head_present,
   input logic        [5:0]  rsp_entry_count
);

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_popped_value)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("stalled response changed");

   // head flag agrees with the count
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_present == (rsp_entry_count != 6'd0)))
      else $error("head flag and entry count disagree");

   // empty queue reports a zero head
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_present |-> rsp_head_value == 32'sd0)
      else $error("empty queue reports a head value");

   // errors never return a value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL)
         |-> rsp_popped_value == 32'sd0)
      else $error("error response carries a popped value");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_popped_value (rsp_popped_value),
   .rsp_status       (rsp_status),
   .rsp_head_value   (rsp_head_value),
   .rsp_head_present (rsp_head_present),
   .rsp_entry_count  (rsp_entry_count)
);

### verif/tb_stable_priority_queue.sv
`timescale 1ns / 1ps
// self-checking testbench of stable_priority_queue: directed and random insert/pop words
// checked against a sorted-list model kept in a scoreboard class; depends on spq_pkg and the rtl
module tb_stable_priority_queue;
   import spq_pkg::*;

   // one expected response word
   typedef struct {
      logic signed [31:0] popped_value;
      logic        [1:0]  status;
      logic signed [31:0] head_value;
      logic               head_present;
      logic        [5:0]  entry_count;
   } rsp_word_type;

   // sorted store model plus the queue of expected responses
   class queue_scoreboard;
      logic signed [31:0] held_value[$];
      logic signed [15:0] held_rank[$];
      rsp_word_type       expected_q[$];
      int                 fail_count;

      function void note_request(logic mode, logic signed [31:0] value,
                                 logic signed [15:0] rank);
         rsp_word_type r;
         int           pos;
         r = '{popped_value: '0, status: ST_OK, head_value: '0,
               head_present: 1'b0, entry_count: '0};
         if (mode == MODE_POP) begin
            // pop on empty leaves the store alone
            if (held_value.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.popped_value = held_value.pop_front();
               void'(held_rank.pop_front());
            end
         end else begin
            if (held_value.size() >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // new entry goes behind every entry of equal or higher rank
               pos = 0;
               while (pos < held_rank.size() && held_rank[pos] >= rank)
                  pos++;
               held_value.insert(pos, value);
               held_rank.insert(pos, rank);
            end
         end
         if (held_value.size() > 0) begin
            r.head_value   = held_value[0];
            r.head_present = 1'b1;
         end
         r.entry_count = 6'(held_value.size());
         expected_q.push_back(r);
      endfunction

      function void check_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_response(logic signed [31:0] popped, logic [1:0] status,
                                   logic signed [31:0] head, logic present,
                                   logic [5:0] count);
         rsp_word_type w;
         if (expected_q.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
            return;
         end
         w = expected_q.pop_front();
         check_field("rsp_popped_value", w.popped_value, popped);
         check_field("rsp_status", w.status, status);
         check_field("rsp_head_value", w.head_value, head);
         check_field("rsp_head_present", w.head_present, present);
         check_field("rsp_entry_count", w.entry_count, count);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_mode          = MODE_INSERT;
   logic signed [31:0] req_item_value    = '0;
   logic signed [15:0] req_item_priority = '0;
   logic               rsp_stall         = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic signed [31:0] rsp_popped_value;
   logic        [1:0]  rsp_status;
   logic signed [31:0] rsp_head_value;
   logic               rsp_head_present;
   logic        [5:0]  rsp_entry_count;

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   bit  hold_req      = 1'b0;
   int  hold_left     = 0;

   queue_scoreboard sb = new();

   stable_priority_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_item_value   (req_item_value),
      .req_item_priority(req_item_priority),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_head_value   (rsp_head_value),
      .rsp_head_present (rsp_head_present),
      .rsp_entry_count  (rsp_entry_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = 80;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor: check accepted responses, then note accepted requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && !rsp_stall)
            sb.check_response(rsp_popped_value, rsp_status, rsp_head_value,
                              rsp_head_present, rsp_entry_count);
         if (req_valid && !req_stall)
            sb.note_request(req_mode, req_item_value, req_item_priority);
      end
   end

   // offer one word after a random gap and wait until it is taken
   task automatic send_word(logic mode, logic signed [31:0] value,
                            logic signed [15:0] rank);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_item_value    <= value;
      req_item_priority <= rank;
      do @(posedge clock); while (req_stall);
   endtask

   // values lean towards the extremes and small numbers
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return 32'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // ranks are often close together so that ties are common
   function automatic logic signed [15:0] pick_rank();
      case ($urandom_range(9))
         0:          return 16'sh7fff;
         1:          return 16'sh8000;
         2, 3, 4, 5: return 16'(int'($urandom_range(3)) - 2);
         default:    return 16'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      int   sent;
      int   run_len;
      int   insert_pct;
      logic mode;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pop on empty queue, with junk in the ignored fields
      send_word(MODE_POP, 32'sh5a5a5a5a, 16'sh1234);
      // extremes of value and rank
      send_word(MODE_INSERT, 32'sh80000000, 16'sh8000);
      send_word(MODE_INSERT, 32'sh7fffffff, 16'sh7fff);
      send_word(MODE_INSERT, 32'sd0, 16'sd0);
      // equal ranks leave in arrival order
      send_word(MODE_INSERT, 32'sd1, 16'sd7);
      send_word(MODE_INSERT, 32'sd2, 16'sd7);
      send_word(MODE_INSERT, 32'sd3, 16'sd7);
      send_word(MODE_INSERT, -32'sd4, 16'sh7fff);
      send_word(MODE_INSERT, 32'sd5, -16'sd1);
      repeat (9) send_word(MODE_POP, 32'sh0, 16'sh0);
      // drained again, pop on empty once more
      send_word(MODE_POP, 32'shffffffff, 16'shffff);

      // random runs: filling, draining and mixed, under one idle and stall setting after another
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         // long receiver hold-off while words keep coming
         if (phase == 0)
            hold_req = 1'b1;
         sent = 0;
         while (sent < 175) begin
            case ($urandom_range(2))
               0:       insert_pct = 85;
               1:       insert_pct = 15;
               default: insert_pct = 55;
            endcase
            run_len = $urandom_range(40, 10);
            if (run_len > 175 - sent)
               run_len = 175 - sent;
            repeat (run_len) begin
               mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_POP;
               send_word(mode, pick_value(), pick_rank());
               sent++;
            end
         end
      end
      req_valid     <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;

      // drain outstanding responses, then let the clock run quietly before the end
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
